>>> design/swcms_pkg.sv
package swcms_pkg;

    // Fixed field and register widths
    localparam int KEY_W   = 32;
    localparam int TS_W    = 32;
    localparam int OUT_W   = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int SHIFT_W = 5;

    // Period buckets per column and the width of a period number
    localparam int PERIODS  = 8;
    localparam int PER_W    = 3;
    localparam int NUM_ROWS = 3;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

    // Word index of the period shift register (paddr bit above the byte offset)
    localparam logic REG_PERIOD_SHIFT = 1'b0;

    typedef logic [1:0] t_row;

    localparam t_row ROW_0    = 2'd0;
    localparam t_row ROW_1    = 2'd1;
    localparam t_row ROW_2    = 2'd2;
    localparam t_row ROW_LAST = ROW_2;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_HASH = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_M1   = 8'b0001_0000,
        S_M2   = 8'b0010_0000,
        S_M3   = 8'b0100_0000,
        S_EST  = 8'b1000_0000
    } t_state;

    // Stage enables for the column update datapath
    typedef struct packed {
        logic m1;
        logic m2;
        logic m3;
        logic est;
        logic first;
    } t_upd_ctl;

endpackage

>>> design/swcms_ram.sv
module swcms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/swcms_col.sv
module swcms_col
    import swcms_pkg::*;
#(
    parameter int COLUMNS = 1024,
    localparam int CB     = $clog2(COLUMNS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_hash [NUM_ROWS],
    output logic             o_done,
    output logic [CB-1:0]    o_col  [NUM_ROWS]
);

    if ((COLUMNS & (COLUMNS - 1)) == 0) begin : g_mask

        logic          r_done;
        logic [CB-1:0] r_col [NUM_ROWS];

        // Power-of-two column count: keep the low hash bits
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    r_col[r] <= i_hash[r][CB-1:0];
                end
            end
        end

        assign o_done = r_done;
        assign o_col  = r_col;

    end else begin : g_div

        // Quotient by reciprocal: q = (x * Recip) >> (KEY_W + CB), exact for 32-bit x.
        // Only the low CB bits of q and of q * COLUMNS are needed for the remainder.
        localparam int LoW = 17;
        localparam int HiW = 16;
        localparam int PW  = KEY_W + 2 * CB;
        localparam longint unsigned Scale = 64'd1 << (KEY_W + CB);
        localparam longint unsigned Recip =
            (Scale + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS);
        localparam logic [LoW-1:0] RecipLo = LoW'(Recip);
        localparam logic [HiW-1:0] RecipHi = HiW'(Recip >> LoW);
        localparam logic [CB-1:0]  ModLow  = CB'(COLUMNS);

        logic [3:0]        r_vld;
        logic              r_done;
        logic [KEY_W-1:0]  r_x   [NUM_ROWS];
        logic [PW-1:0]     r_plo [NUM_ROWS];
        logic [PW-LoW-1:0] r_phi [NUM_ROWS];
        logic [PW-1:0]     prod  [NUM_ROWS];
        logic [CB-1:0]     r_q   [NUM_ROWS];
        logic [CB-1:0]     r_qd  [NUM_ROWS];
        logic [CB-1:0]     r_rem [NUM_ROWS];

        // Join the two partial products
        always_comb begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                prod[r] = {r_phi[r], {LoW{1'b0}}} + r_plo[r];
            end
        end

        // Advance the stage marks; o_done rises as the remainder is ready
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld  <= '0;
                r_done <= 1'b0;
            end else begin
                r_vld  <= {r_vld[2:0], i_start};
                r_done <= r_vld[3];
            end
        end

        // Hold the hash, multiply, take the quotient bits, multiply back, subtract
        always_ff @(posedge i_clk) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                if (i_start) begin
                    r_x[r] <= i_hash[r];
                end
                r_plo[r] <= PW'(r_x[r]) * PW'(RecipLo);
                r_phi[r] <= (PW-LoW)'(r_x[r]) * (PW-LoW)'(RecipHi);
                r_q[r]   <= prod[r][KEY_W+CB +: CB];
                r_qd[r]  <= r_q[r] * ModLow;
                r_rem[r] <= r_x[r][CB-1:0] - r_qd[r];
            end
        end

        assign o_done = r_done;
        assign o_col  = r_rem;

    end

endmodule

>>> design/swcms_upd.sv
module swcms_upd
    import swcms_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    localparam int CW         = COUNT_WIDTH,
    localparam int WordW      = PERIODS * CW + PER_W + CW
) (
    input  logic             i_clk,
    input  t_upd_ctl         i_ctl,
    input  logic [PER_W-1:0] i_per,
    input  logic [WordW-1:0] i_rd_data,
    output logic [WordW-1:0] o_wr_data,
    output logic [CW-1:0]    o_min
);

    localparam logic [CW-1:0] CntMax = '1;
    localparam int TotLsb = 0;
    localparam int PerLsb = CW;
    localparam int BkLsb  = CW + PER_W;
    localparam logic [PER_W:0] SpanMax = (PER_W + 1)'(PERIODS);

    logic [PER_W-1:0] last_per;
    logic [PER_W-1:0] span;
    logic             same;
    logic [CW-1:0]    old_tot;
    logic [PER_W-1:0] off_last [PERIODS];
    logic [PER_W-1:0] off_cur  [PERIODS];
    logic [CW-1:0]    bk       [PERIODS];
    logic [CW-1:0]    n_bk     [PERIODS];
    logic [CW-1:0]    masked   [PERIODS];
    logic [CW:0]      pair     [PERIODS/2];
    logic [CW+2:0]    sum;
    logic [CW-1:0]    tot;
    logic [CW:0]      est_sum;
    logic [CW-1:0]    est;

    logic [CW-1:0]    r_bk     [PERIODS];
    logic             r_same;
    logic [CW-1:0]    r_old_tot;
    logic [CW:0]      r_pair   [PERIODS/2];
    logic [CW+1:0]    r_quad   [2];
    logic [CW-1:0]    r_cur;
    logic [CW-1:0]    r_tot;
    logic [CW-1:0]    r_min;

    // Update the buckets of the column word and pick those that fold into the total
    always_comb begin
        last_per = i_rd_data[PerLsb +: PER_W];
        old_tot  = i_rd_data[TotLsb +: CW];
        same     = (i_per == last_per);
        span     = i_per - last_per;
        for (int j = 0; j < PERIODS; j++) begin
            bk[j]       = i_rd_data[BkLsb + j*CW +: CW];
            off_last[j] = PER_W'(j) - last_per;
            off_cur[j]  = PER_W'(j) - i_per;
            if (PER_W'(j) == i_per) begin
                if (same) begin
                    n_bk[j] = (bk[j] == CntMax) ? CntMax : bk[j] + CW'(1);
                end else begin
                    n_bk[j] = CW'(1);
                end
            end else if (!same && (off_last[j] != '0) && (off_last[j] < span)) begin
                n_bk[j] = '0;
            end else begin
                n_bk[j] = bk[j];
            end
            if (!same && (off_cur[j] != '0)
                    && (({1'b0, off_cur[j]} + {1'b0, span}) <= SpanMax)) begin
                masked[j] = bk[j];
            end else begin
                masked[j] = '0;
            end
        end
        for (int p = 0; p < PERIODS/2; p++) begin
            pair[p] = {1'b0, masked[2*p]} + {1'b0, masked[2*p+1]};
        end
    end

    // Final sum and clamp (old total kept when the period is unchanged), and the word written back
    always_comb begin
        sum = {1'b0, r_quad[0]} + {1'b0, r_quad[1]};
        if (r_same) begin
            tot = r_old_tot;
        end else if (sum > (CW+3)'(CntMax)) begin
            tot = CntMax;
        end else begin
            tot = sum[CW-1:0];
        end
        o_wr_data[TotLsb +: CW]    = tot;
        o_wr_data[PerLsb +: PER_W] = i_per;
        for (int j = 0; j < PERIODS; j++) begin
            o_wr_data[BkLsb + j*CW +: CW] = r_bk[j];
        end
    end

    // Row estimate: current bucket plus older total, saturated
    always_comb begin
        est_sum = {1'b0, r_cur} + {1'b0, r_tot};
        est     = est_sum[CW] ? CntMax : est_sum[CW-1:0];
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.m1) begin
            r_bk      <= n_bk;
            r_same    <= same;
            r_old_tot <= old_tot;
            r_pair    <= pair;
        end
        if (i_ctl.m2) begin
            r_quad[0] <= {1'b0, r_pair[0]} + {1'b0, r_pair[1]};
            r_quad[1] <= {1'b0, r_pair[2]} + {1'b0, r_pair[3]};
        end
        if (i_ctl.m3) begin
            r_cur <= r_bk[i_per];
            r_tot <= tot;
        end
        if (i_ctl.est) begin
            if (i_ctl.first || (est < r_min)) begin
                r_min <= est;
            end
        end
    end

    assign o_min = r_min;

endmodule

>>> design/sliding_window_count_min_sketch_top.sv
// Sliding-window count-min sketch, three rows. Raise start with the two keys and
// the timestamp while busy is low; the estimate appears on o_count_estimate with
// o_valid high for exactly one cycle and must be captured then, since it cannot be
// held off. An item occupies the block longer when COLUMNS is not a power of two,
// as the column index then comes from a pipelined reciprocal multiply; busy falls
// in the cycle o_valid is shown, so the next item may start there. The single
// column memory serves the rows one after another: each row takes a read, a
// three-stage update and sum with the write-back in its last stage, and an estimate
// step, during which the next row is read. After reset the block clears the column
// memory, one word a cycle, with busy high; period_shift may be written at any time
// through the register port, but only while idle for a defined result.
module sliding_window_count_min_sketch_top
    import swcms_pkg::*;
#(
    parameter int COLUMNS     = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KEY_W-1:0]  i_key_a,
    input  logic [KEY_W-1:0]  i_key_b,
    input  logic [TS_W-1:0]   i_timestamp,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_count_estimate,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int Depth = NUM_ROWS * COLUMNS;
    localparam int AW    = $clog2(Depth);
    localparam int CB    = $clog2(COLUMNS);
    localparam int CW    = COUNT_WIDTH;
    localparam int WordW = PERIODS * CW + PER_W + CW;
    localparam logic [AW-1:0] AddrLast = AW'(Depth - 1);
    localparam logic [AW-1:0] RowBase1 = AW'(COLUMNS);
    localparam logic [AW-1:0] RowBase2 = AW'(2 * COLUMNS);

    t_state             r_state, n_state;
    logic [SHIFT_W-1:0] r_shift;
    logic [PER_W-1:0]   r_per;
    t_row               r_row;
    logic [AW-1:0]      r_clr;
    logic               r_valid;

    logic               accept;
    logic               cfg_wr;
    logic [KEY_W-1:0]   hash [NUM_ROWS];
    logic               col_done;
    logic [CB-1:0]      col  [NUM_ROWS];
    t_row               rd_row;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               mem_re;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [WordW-1:0]   mem_wdata;
    logic [WordW-1:0]   mem_rdata;
    logic [WordW-1:0]   upd_wdata;
    logic [CW-1:0]      upd_min;
    t_upd_ctl           upd_ctl;
    logic [TS_W-1:0]    ts_shifted;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Row hashes
    assign hash[0] = i_key_a ^ i_key_b;
    assign hash[1] = i_key_a | i_key_b;
    assign hash[2] = i_key_a & i_key_b;

    assign ts_shifted = i_timestamp >> r_shift;

    // Register port: a single writable register, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1] == REG_PERIOD_SHIFT);
    assign prdata = (paddr[ADDR_W-1] == REG_PERIOD_SHIFT) ? DATA_W'(r_shift) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (cfg_wr) begin
            r_shift <= pwdata[SHIFT_W-1:0];
        end
    end

    // Sequencer: clear pass, then one read-modify-write per row
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == AddrLast) n_state = S_IDLE;
            S_IDLE: if (accept) n_state = S_HASH;
            S_HASH: if (col_done) n_state = S_RD;
            S_RD:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_EST;
            S_EST:  n_state = (r_row == ROW_LAST) ? S_IDLE : S_M1;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_row   <= ROW_0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EST) && (r_row == ROW_LAST);
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_RD) begin
                r_row <= ROW_0;
            end else if (r_state == S_EST) begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    // Hold the period of the item in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_per <= ts_shifted[PER_W-1:0];
        end
    end

    // Column addresses: read the next row while the current one finishes
    assign rd_row = (r_state == S_RD) ? ROW_0 : r_row + 1'b1;

    always_comb begin
        case (rd_row)
            ROW_1:   rd_addr = RowBase1 + AW'(col[1]);
            ROW_2:   rd_addr = RowBase2 + AW'(col[2]);
            default: rd_addr = AW'(col[0]);
        endcase
        case (r_row)
            ROW_1:   wr_addr = RowBase1 + AW'(col[1]);
            ROW_2:   wr_addr = RowBase2 + AW'(col[2]);
            default: wr_addr = AW'(col[0]);
        endcase
    end

    // Rows touch distinct words and items never overlap, so no forwarding is needed
    assign mem_re    = (r_state == S_RD) || ((r_state == S_EST) && (r_row != ROW_LAST));
    assign mem_we    = (r_state == S_CLR) || (r_state == S_M3);
    assign mem_waddr = (r_state == S_CLR) ? r_clr : wr_addr;
    assign mem_wdata = (r_state == S_CLR) ? '0 : upd_wdata;

    assign upd_ctl.m1    = (r_state == S_M1);
    assign upd_ctl.m2    = (r_state == S_M2);
    assign upd_ctl.m3    = (r_state == S_M3);
    assign upd_ctl.est   = (r_state == S_EST);
    assign upd_ctl.first = (r_row == ROW_0);

    swcms_col #(
        .COLUMNS (COLUMNS)
    ) u_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_hash  (hash),
        .o_done  (col_done),
        .o_col   (col)
    );

    swcms_ram #(
        .WIDTH (WordW),
        .DEPTH (Depth)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    swcms_upd #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_upd (
        .i_clk     (i_clk),
        .i_ctl     (upd_ctl),
        .i_per     (r_per),
        .i_rd_data (mem_rdata),
        .o_wr_data (upd_wdata),
        .o_min     (upd_min)
    );

    assign o_valid          = r_valid;
    assign o_count_estimate = OUT_W'(upd_min);

endmodule

>>> design/swcms_chk.sv
module swcms_chk
    import swcms_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // No result in the cycle after an item is accepted
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result shown right after acceptance");

    // A result ends the busy period of its item
    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result not at the end of a busy period");

    // Each result transfer lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A written period shift reads back
    a_shift_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_PERIOD_SHIFT))
        |=> ((paddr[ADDR_W-1] != REG_PERIOD_SHIFT)
             || (prdata == DATA_W'($past(pwdata[SHIFT_W-1:0])))))
        else $error("period shift read-back mismatch");

endmodule

bind sliding_window_count_min_sketch_top swcms_chk u_chk (.*);
